[src/lli_pkg.sv]
package lli_pkg;

  localparam int unsigned DIR_FRAC_BITS = 30;

  // operand and datapath widths
  localparam int unsigned NUM_W     = 66;  // numerator magnitude (Q.46)
  localparam int unsigned DEN_W     = 35;  // |det| (Q.30)
  localparam int unsigned DIV_STEPS = 34;  // quotient bits resolved by the divider
  localparam int unsigned REM_W     = NUM_W + 3;

  // register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_DIR_X    = 3'd2;
  localparam logic [2:0] REG_DIR_Y    = 3'd3;
  localparam logic [2:0] REG_TOL      = 3'd4;

  typedef struct packed {
    logic signed [31:0] rox;
    logic signed [31:0] roy;
    logic signed [31:0] rdx;
    logic signed [31:0] rdy;
    logic        [30:0] tol;
  } cfg_t;

  typedef struct packed {
    logic vld;
    logic par;
  } ctl_t;

  typedef struct packed {
    ctl_t              ctl;
    logic [NUM_W-1:0]  num_t;
    logic [NUM_W-1:0]  num_s;
    logic              neg_t;
    logic              neg_s;
    logic [DEN_W-1:0]  den;
  } div_in_t;

endpackage

[src/line_line_intersection.sv]
// Line crossing against a reference line held in registers.
// Config: APB-style write port; registers at byte address 4*i:
//   0 ref origin x, 1 ref origin y (Q16.16), 2 ref dir x, 3 ref dir y (Q2.30),
//   4 parallel tolerance (31 bits, Q1.30). Reads return the stored value.
//   Write config only while the pipeline is empty.
// Input item: other line origin (Q16.16) and direction (Q2.30), taken when
//   in_valid_i is high and in_stall_o low.
// Result item: intersects flag, t and s (Q16.16), crossing point; all zero
//   when |det| is at or below the tolerance. Taken when out_valid_o is high
//   and out_stall_i low.
// Pipeline: 3 front stages (products, det/numerators, magnitudes),
//   36 divider stages (one quotient bit per stage plus overflow check and
//   saturation), 2 point stages. Throughput one item per cycle unless a
//   result waits under out_stall_i; the 34-step restoring divider sets the depth.
// Reset: pipeline empties, registers take their reset values.
// Stall: while a result waits under out_stall_i the whole pipeline holds and
//   in_stall_o is raised; nothing is dropped or repeated.
module line_line_intersection (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] other_origin_x_i,
  input  logic signed [31:0] other_origin_y_i,
  input  logic signed [31:0] other_dir_x_i,
  input  logic signed [31:0] other_dir_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               intersects_o,
  output logic signed [31:0] ref_param_o,
  output logic signed [31:0] other_param_o,
  output logic signed [31:0] cross_x_o,
  output logic signed [31:0] cross_y_o
);

  // ---- configuration registers
  lli_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rox <= '0;
      cfg_q.roy <= '0;
      cfg_q.rdx <= 32'sh40000000;
      cfg_q.rdy <= '0;
      cfg_q.tol <= 31'd1074;
    end else if (wr_en) begin
      case (idx)
        lli_pkg::REG_ORIGIN_X: cfg_q.rox <= pwdata;
        lli_pkg::REG_ORIGIN_Y: cfg_q.roy <= pwdata;
        lli_pkg::REG_DIR_X:    cfg_q.rdx <= pwdata;
        lli_pkg::REG_DIR_Y:    cfg_q.rdy <= pwdata;
        lli_pkg::REG_TOL:      cfg_q.tol <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lli_pkg::REG_ORIGIN_X: prdata = cfg_q.rox;
      lli_pkg::REG_ORIGIN_Y: prdata = cfg_q.roy;
      lli_pkg::REG_DIR_X:    prdata = cfg_q.rdx;
      lli_pkg::REG_DIR_Y:    prdata = cfg_q.rdy;
      lli_pkg::REG_TOL:      prdata = {1'b0, cfg_q.tol};
      default:               prdata = '0;
    endcase
  end

  // ---- pipeline advance: hold everything while a result is stalled
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  lli_pkg::div_in_t   div_in;
  lli_pkg::ctl_t      div_ctl;
  logic signed [31:0] t_v, s_v;

  lli_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .o2x_i  (other_origin_x_i),
    .o2y_i  (other_origin_y_i),
    .d2x_i  (other_dir_x_i),
    .d2y_i  (other_dir_y_i),
    .cfg_i  (cfg_q),
    .div_o  (div_in)
  );

  lli_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .div_i  (div_in),
    .ctl_o  (div_ctl),
    .t_o    (t_v),
    .s_o    (s_v)
  );

  lli_point u_point (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .ctl_i         (div_ctl),
    .t_i           (t_v),
    .s_i           (s_v),
    .cfg_i         (cfg_q),
    .vld_o         (out_valid_o),
    .intersects_o  (intersects_o),
    .ref_param_o   (ref_param_o),
    .other_param_o (other_param_o),
    .cross_x_o     (cross_x_o),
    .cross_y_o     (cross_y_o)
  );

  // ---- checks
  a_par_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !intersects_o |->
      ref_param_o == 0 && other_param_o == 0 && cross_x_o == 0 && cross_y_o == 0)
    else $error("parallel result not zero");

  a_flat_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && intersects_o && cfg_q.rdy == 0 |-> cross_y_o == cfg_q.roy)
    else $error("crossing y off a horizontal reference line");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

endmodule

[src/lli_front.sv]
module lli_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic signed [31:0]  o2x_i,
  input  logic signed [31:0]  o2y_i,
  input  logic signed [31:0]  d2x_i,
  input  logic signed [31:0]  d2y_i,
  input  lli_pkg::cfg_t       cfg_i,
  output lli_pkg::div_in_t    div_o
);

  // stage 1: direction products, origin offset
  logic               v1_q;
  logic signed [63:0] p1_q, p1_d, p2_q, p2_d;
  logic signed [32:0] ox_q, ox_d, oy_q, oy_d;
  logic signed [31:0] d2x_q, d2y_q;

  assign p1_d = d2x_i * cfg_i.rdy;
  assign p2_d = d2y_i * cfg_i.rdx;
  assign ox_d = 33'(o2x_i) - 33'(cfg_i.rox);
  assign oy_d = 33'(o2y_i) - 33'(cfg_i.roy);

  // stage 2: det, numerator products
  logic               v2_q;
  logic signed [64:0] full;
  logic signed [34:0] det_q, det_d;
  logic signed [64:0] m1_q, m1_d, m2_q, m2_d, m3_q, m3_d, m4_q, m4_d;

  assign full  = 65'(p1_q) - 65'(p2_q);
  assign det_d = 35'(full >>> lli_pkg::DIR_FRAC_BITS);
  assign m1_d  = d2x_q * oy_q;
  assign m2_d  = d2y_q * ox_q;
  assign m3_d  = cfg_i.rdx * oy_q;
  assign m4_d  = cfg_i.rdy * ox_q;

  // stage 3: numerators, magnitudes, parallel test
  logic signed [65:0]          nt, ns;
  logic [lli_pkg::DEN_W-1:0]   dmag;
  lli_pkg::div_in_t            div_q, div_d;

  assign nt   = 66'(m1_q) - 66'(m2_q);
  assign ns   = 66'(m3_q) - 66'(m4_q);
  assign dmag = det_q[34] ? lli_pkg::DEN_W'(-det_q) : lli_pkg::DEN_W'(det_q);

  always_comb begin
    div_d.ctl.vld = v2_q;
    div_d.ctl.par = dmag <= lli_pkg::DEN_W'(cfg_i.tol);
    div_d.num_t   = nt[65] ? lli_pkg::NUM_W'(-nt) : lli_pkg::NUM_W'(nt);
    div_d.num_s   = ns[65] ? lli_pkg::NUM_W'(-ns) : lli_pkg::NUM_W'(ns);
    div_d.neg_t   = nt[65] ^ det_q[34];
    div_d.neg_s   = ns[65] ^ det_q[34];
    div_d.den     = dmag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      div_q <= '0;
    end else if (en_i) begin
      v1_q  <= vld_i;
      v2_q  <= v1_q;
      div_q <= div_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      ox_q  <= ox_d;
      oy_q  <= oy_d;
      d2x_q <= d2x_i;
      d2y_q <= d2y_i;
      det_q <= det_d;
      m1_q  <= m1_d;
      m2_q  <= m2_d;
      m3_q  <= m3_d;
      m4_q  <= m4_d;
    end
  end

  assign div_o = div_q;

endmodule

[src/lli_div.sv]
module lli_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  lli_pkg::div_in_t   div_i,
  output lli_pkg::ctl_t      ctl_o,
  output logic signed [31:0] t_o,
  output logic signed [31:0] s_o
);

  localparam int unsigned N = lli_pkg::DIV_STEPS;

  // lane 0 is t, lane 1 is s; one restoring step per stage
  lli_pkg::ctl_t              ctl_q [0:N];
  logic [lli_pkg::DEN_W-1:0]  den_q [0:N];
  logic [lli_pkg::NUM_W-1:0]  rem_q [0:1][0:N];
  logic [N-1:0]               quo_q [0:1][0:N];
  logic                       ovf_q [0:1][0:N];
  logic                       neg_q [0:1][0:N];

  logic [lli_pkg::NUM_W-1:0]  num_in [0:1];
  logic                       neg_in [0:1];

  assign num_in[0] = div_i.num_t;
  assign num_in[1] = div_i.num_s;
  assign neg_in[0] = div_i.neg_t;
  assign neg_in[1] = div_i.neg_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= N; j++) ctl_q[j] <= '0;
    end else if (en_i) begin
      ctl_q[0] <= div_i.ctl;
      for (int j = 1; j <= N; j++) ctl_q[j] <= ctl_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= div_i.den;
      for (int j = 1; j <= N; j++) begin
        den_q[j] <= den_q[j-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    // quotient at or above 2^N saturates regardless of the low bits
    logic ovf0;
    assign ovf0 = lli_pkg::REM_W'(num_in[l]) >=
                  (lli_pkg::REM_W'(div_i.den) << N);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[l][0] <= num_in[l];
        quo_q[l][0] <= '0;
        ovf_q[l][0] <= ovf0;
        neg_q[l][0] <= neg_in[l];
      end
    end

    for (genvar j = 1; j <= N; j++) begin : g_step
      localparam int unsigned SH = N - j;
      logic [lli_pkg::REM_W-1:0] dsh, rw;
      logic                      ge;
      assign dsh = lli_pkg::REM_W'(den_q[j-1]) << SH;
      assign rw  = lli_pkg::REM_W'(rem_q[l][j-1]);
      assign ge  = rw >= dsh;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[l][j] <= ge ? lli_pkg::NUM_W'(rw - dsh) : rem_q[l][j-1];
          quo_q[l][j] <= {quo_q[l][j-1][N-2:0], ge};
          ovf_q[l][j] <= ovf_q[l][j-1];
          neg_q[l][j] <= neg_q[l][j-1];
        end
      end
    end
  end

  // sign and saturate to 32 bits
  logic signed [31:0] res_d [0:1];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (neg_q[l][N]) begin
        if (ovf_q[l][N] || quo_q[l][N] > N'(33'h080000000)) res_d[l] = 32'sh80000000;
        else res_d[l] = 32'(-quo_q[l][N]);
      end else begin
        if (ovf_q[l][N] || quo_q[l][N] > N'(33'h07FFFFFFF)) res_d[l] = 32'sh7FFFFFFF;
        else res_d[l] = 32'(quo_q[l][N]);
      end
    end
  end

  lli_pkg::ctl_t      ctl_out_q;
  logic signed [31:0] t_q, s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_out_q <= '0;
    end else if (en_i) begin
      ctl_out_q <= ctl_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= res_d[0];
      s_q <= res_d[1];
    end
  end

  assign ctl_o = ctl_out_q;
  assign t_o   = t_q;
  assign s_o   = s_q;

endmodule

[src/lli_point.sv]
module lli_point (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  lli_pkg::ctl_t      ctl_i,
  input  logic signed [31:0] t_i,
  input  logic signed [31:0] s_i,
  input  lli_pkg::cfg_t      cfg_i,
  output logic               vld_o,
  output logic               intersects_o,
  output logic signed [31:0] ref_param_o,
  output logic signed [31:0] other_param_o,
  output logic signed [31:0] cross_x_o,
  output logic signed [31:0] cross_y_o
);

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sh07FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -35'sh080000000) return 32'sh80000000;
    return 32'(v);
  endfunction

  lli_pkg::ctl_t      ctl_q;
  logic signed [63:0] px_q, px_d, py_q, py_d;
  logic signed [31:0] t_q, s_q;

  assign px_d = cfg_i.rdx * t_i;
  assign py_d = cfg_i.rdy * t_i;

  logic signed [34:0] sx, sy;
  assign sx = 35'(cfg_i.rox) + 35'(px_q >>> lli_pkg::DIR_FRAC_BITS);
  assign sy = 35'(cfg_i.roy) + 35'(py_q >>> lli_pkg::DIR_FRAC_BITS);

  logic               vld_q, hit_q;
  logic signed [31:0] rp_q, op_q, cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      vld_q <= 1'b0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
      vld_q <= ctl_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q      <= px_d;
      py_q      <= py_d;
      t_q       <= t_i;
      s_q       <= s_i;
      hit_q     <= !ctl_q.par;
      rp_q      <= ctl_q.par ? '0 : t_q;
      op_q      <= ctl_q.par ? '0 : s_q;
      cx_q      <= ctl_q.par ? '0 : sat32(sx);
      cy_q      <= ctl_q.par ? '0 : sat32(sy);
    end
  end

  assign vld_o         = vld_q;
  assign intersects_o  = hit_q;
  assign ref_param_o   = rp_q;
  assign other_param_o = op_q;
  assign cross_x_o     = cx_q;
  assign cross_y_o     = cy_q;

endmodule
